// ----- rtl/pdq_pkg.sv -----
`default_nettype none
package pdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SORT       = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

endpackage
`default_nettype wire

// ----- rtl/pdq_ram.sv -----
`default_nettype none
module pdq_ram #(
    parameter int DEPTH = pdq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire pdq_pkg::word_t  wdata,
    input  wire logic [AW-1:0]   raddr,
    output pdq_pkg::word_t       rdata
);

    pdq_pkg::word_t mem [DEPTH];
    pdq_pkg::word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/positional_deque_with_sort.sv -----
// Channel   Direction  Signals
// s_        in         s_valid, s_ready, s_func, s_position, s_value
// m_        out        m_valid, m_ready, m_popped_value, m_count, m_status
//
// One transaction at a time; s_ready is high only while the sequencer idles.
// Insert/push moves entries from the position on up one, then writes; remove/pop reads
// the entry, then moves later entries down. Sort: a selection sort over the single memory
// read port and comparator. Clear and failed commands go straight to the result. aresetn
// is sync. A result waits in the output register; the next command is taken meanwhile.
`default_nettype none
module positional_deque_with_sort #(
    parameter int DEPTH = pdq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [pdq_pkg::FUNC_W-1:0]  s_func,
    input  wire logic [CW-1:0]               s_position,
    input  wire pdq_pkg::word_t              s_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pdq_pkg::word_t                   m_popped_value,
    output logic [CW-1:0]                    m_count,
    output logic [pdq_pkg::STAT_W-1:0]       m_status
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIN    = 4'd1;
    localparam logic [3:0] S_INS    = 4'd2;
    localparam logic [3:0] S_INS_W  = 4'd3;
    localparam logic [3:0] S_RM_R0  = 4'd4;
    localparam logic [3:0] S_RM_CAP = 4'd5;
    localparam logic [3:0] S_RM     = 4'd6;
    localparam logic [3:0] S_RM_W   = 4'd7;
    localparam logic [3:0] S_SO_I   = 4'd8;
    localparam logic [3:0] S_SO_IC  = 4'd9;
    localparam logic [3:0] S_SO_J   = 4'd10;
    localparam logic [3:0] S_SO_JC  = 4'd11;
    localparam logic [3:0] S_SO_SW  = 4'd12;
    localparam logic [3:0] S_SO_SW2 = 4'd13;

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    logic [3:0]                   state_reg, state_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [CW-1:0]                m_reg, m_next;
    pdq_pkg::word_t               val_reg, val_next;
    pdq_pkg::word_t               iv_reg, iv_next;
    pdq_pkg::word_t               minv_reg, minv_next;
    pdq_pkg::word_t               pop_reg, pop_next;
    logic [pdq_pkg::STAT_W-1:0]   st_reg, st_next;
    logic                         ovalid_reg, ovalid_next;
    pdq_pkg::word_t               opop_reg, opop_next;
    logic [CW-1:0]                ocnt_reg, ocnt_next;
    logic [pdq_pkg::STAT_W-1:0]   ost_reg, ost_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    pdq_pkg::word_t  ram_wdata, ram_rdata;
    logic [CW-1:0]   i_dec, i_inc;
    logic            accept;

    pdq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready        = (state_reg == S_IDLE);
    assign accept         = s_valid && s_ready;
    assign i_dec          = i_reg - ONE;
    assign i_inc          = i_reg + ONE;
    assign m_valid        = ovalid_reg;
    assign m_popped_value = opop_reg;
    assign m_count        = ocnt_reg;
    assign m_status       = ost_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        val_next    = val_reg;
        iv_next     = iv_reg;
        minv_next   = minv_reg;
        pop_next    = pop_reg;
        st_next     = st_reg;
        ovalid_next = ovalid_reg && !m_ready;
        opop_next   = opop_reg;
        ocnt_next   = ocnt_reg;
        ost_next    = ost_reg;
        ram_we      = 1'b0;
        ram_waddr   = i_reg[AW-1:0];
        ram_wdata   = val_reg;
        ram_raddr   = i_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pop_next   = '0;
                    st_next    = pdq_pkg::ST_OK;
                    val_next   = s_value;
                    state_next = S_FIN;
                    case (s_func)
                        pdq_pkg::FN_PUSH_FRONT, pdq_pkg::FN_PUSH_BACK,
                        pdq_pkg::FN_INSERT: begin
                            if (cnt_reg == FULL_CNT) begin
                                st_next = pdq_pkg::ST_FULL;
                            end else if (s_func == pdq_pkg::FN_PUSH_FRONT) begin
                                pos_next   = '0;
                                i_next     = cnt_reg;
                                state_next = S_INS;
                            end else if (s_func == pdq_pkg::FN_PUSH_BACK) begin
                                pos_next   = cnt_reg;
                                i_next     = cnt_reg;
                                state_next = S_INS;
                            end else if (s_position > cnt_reg) begin
                                st_next = pdq_pkg::ST_RANGE;
                            end else begin
                                pos_next   = s_position;
                                i_next     = cnt_reg;
                                state_next = S_INS;
                            end
                        end
                        pdq_pkg::FN_POP_FRONT, pdq_pkg::FN_POP_BACK,
                        pdq_pkg::FN_REMOVE: begin
                            if (cnt_reg == '0) begin
                                st_next = pdq_pkg::ST_EMPTY;
                            end else if (s_func == pdq_pkg::FN_POP_FRONT) begin
                                pos_next   = '0;
                                state_next = S_RM_R0;
                            end else if (s_func == pdq_pkg::FN_POP_BACK) begin
                                pos_next   = cnt_reg - ONE;
                                state_next = S_RM_R0;
                            end else if (s_position >= cnt_reg) begin
                                st_next = pdq_pkg::ST_RANGE;
                            end else begin
                                pos_next   = s_position;
                                state_next = S_RM_R0;
                            end
                        end
                        pdq_pkg::FN_CLEAR: begin
                            cnt_next = '0;
                        end
                        default: begin
                            i_next     = '0;
                            state_next = S_SO_I;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (i_reg == pos_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    cnt_next   = cnt_reg + ONE;
                    state_next = S_FIN;
                end else begin
                    ram_raddr  = i_dec[AW-1:0];
                    state_next = S_INS_W;
                end
            end
            S_INS_W: begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                i_next     = i_dec;
                state_next = S_INS;
            end
            S_RM_R0: begin
                ram_raddr  = pos_reg[AW-1:0];
                state_next = S_RM_CAP;
            end
            S_RM_CAP: begin
                pop_next   = ram_rdata;
                i_next     = pos_reg;
                state_next = S_RM;
            end
            S_RM: begin
                if (i_inc >= cnt_reg) begin
                    cnt_next   = cnt_reg - ONE;
                    state_next = S_FIN;
                end else begin
                    ram_raddr  = i_inc[AW-1:0];
                    state_next = S_RM_W;
                end
            end
            S_RM_W: begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                i_next     = i_inc;
                state_next = S_RM;
            end
            S_SO_I: begin
                if (i_inc >= cnt_reg) begin
                    state_next = S_FIN;
                end else begin
                    ram_raddr  = i_reg[AW-1:0];
                    state_next = S_SO_IC;
                end
            end
            S_SO_IC: begin
                iv_next    = ram_rdata;
                minv_next  = ram_rdata;
                m_next     = i_reg;
                j_next     = i_inc;
                state_next = S_SO_J;
            end
            S_SO_J: begin
                if (j_reg >= cnt_reg) begin
                    state_next = S_SO_SW;
                end else begin
                    ram_raddr  = j_reg[AW-1:0];
                    state_next = S_SO_JC;
                end
            end
            S_SO_JC: begin
                if (ram_rdata < minv_reg) begin
                    minv_next = ram_rdata;
                    m_next    = j_reg;
                end
                j_next     = j_reg + ONE;
                state_next = S_SO_J;
            end
            S_SO_SW: begin
                if (m_reg != i_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = m_reg[AW-1:0];
                    ram_wdata  = iv_reg;
                    state_next = S_SO_SW2;
                end else begin
                    i_next     = i_inc;
                    state_next = S_SO_I;
                end
            end
            S_SO_SW2: begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg[AW-1:0];
                ram_wdata  = minv_reg;
                i_next     = i_inc;
                state_next = S_SO_I;
            end
            S_FIN: begin
                if (!ovalid_reg || m_ready) begin
                    ovalid_next = 1'b1;
                    opop_next   = pop_reg;
                    ocnt_next   = cnt_reg;
                    ost_next    = st_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
        pos_reg  <= pos_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        m_reg    <= m_next;
        val_reg  <= val_next;
        iv_reg   <= iv_next;
        minv_reg <= minv_next;
        pop_reg  <= pop_next;
        st_reg   <= st_next;
        opop_reg <= opop_next;
        ocnt_reg <= ocnt_next;
        ost_reg  <= ost_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("element count above depth");

    a_fin_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!ovalid_reg || m_ready)) |=> (m_valid && s_ready))
        else $error("result not presented after completion");

    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == pdq_pkg::ST_EMPTY) |-> (m_count == '0))
        else $error("empty status with nonzero count");

    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == pdq_pkg::ST_FULL) |-> (m_count == FULL_CNT))
        else $error("full status with count below depth");

endmodule
`default_nettype wire
